### hdl/crcrd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcrd_pkg
// Shared types, codes and the CRC-16/MODBUS byte step for the response
// deframer.
// ----------------------------------------------------------------------------
package crcrd_pkg;

  // Default limit on the payload length in a response header
  localparam int MAX_PAYLOAD_DEF = 512;

  localparam int BYTE_W    = 8;
  localparam int CMD_W     = 2;
  localparam int STATUS_W  = 3;
  localparam int OUT_LEN_W = 10;
  localparam int FRAME_W   = 16;
  localparam int CRC_W     = 16;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  // Input commands
  localparam logic [CMD_W-1:0] CMD_BYTE    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_START   = 2'd2;

  // Status codes of the final item
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_CRC  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_MISMATCH = 3'd3;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 3'd4;

  // Register indexes (word index on the configuration port)
  localparam logic REG_ADDRESS = 1'b0;
  localparam logic REG_OPCODE  = 1'b1;

  localparam logic [BYTE_W-1:0] ADDRESS_RESET = 8'h01;
  localparam logic [BYTE_W-1:0] OPCODE_RESET  = 8'h00;

  localparam logic [CRC_W-1:0]     CRC_INIT = 16'hFFFF;
  localparam logic [CRC_W-1:0]     CRC_POLY = 16'hA001;
  localparam logic [OUT_LEN_W-1:0] LEN_SAT  = 10'h3FF;

  // Control from the deframer to the CRC unit
  typedef struct packed {
    logic rearm;
    logic absorb;
  } crc_ctl_t;

  // One byte of the reflected CRC-16/MODBUS update, LSB first
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc_in,
                                                  input logic [BYTE_W-1:0] data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < BYTE_W; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

### hdl/crc_checked_response_deframer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crc_checked_response_deframer
// Deframes a response (address, command, length, payload, CRC-16/MODBUS),
// streams payload bytes and closes each frame with one status item unless a start drops it.
// ----------------------------------------------------------------------------
//
//  channel | handshake               | payload
//  --------+-------------------------+------------------------------------------
//  in      | in_valid / in_stall     | command, line_byte
//  out     | out_valid / out_stall   | payload_byte, is_status, status,
//          |                         | payload_length
//  cfg     | psel/penable/pwrite/... | paddr, pwdata, prdata (0: address, 4: opcode)
//
//  One transaction per cycle in both directions unless stalled; each
//  input transaction is fully handled by the logic between the input and
//  the result register. Results leave the block from the result register.
//  A skid register behind the result register lets one more transaction in
//  while out is stalled; in_stall rises only once the skid register is full.
//  rst (synchronous) arms the block for a new frame and restores the
//  register defaults (address 1, opcode 0).
//
module crc_checked_response_deframer #(
  parameter int MAX_PAYLOAD = crcrd_pkg::MAX_PAYLOAD_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  // input channel
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [crcrd_pkg::CMD_W-1:0]           command,
  input  wire  [crcrd_pkg::BYTE_W-1:0]          line_byte,
  // output channel
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [crcrd_pkg::BYTE_W-1:0]          payload_byte,
  output logic                                  is_status,
  output logic [crcrd_pkg::STATUS_W-1:0]        status,
  output logic [crcrd_pkg::OUT_LEN_W-1:0]       payload_length,
  // configuration port
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire  [crcrd_pkg::APB_AW-1:0]          paddr,
  input  wire  [crcrd_pkg::APB_DW-1:0]          pwdata,
  output logic [crcrd_pkg::APB_DW-1:0]          prdata,
  output logic                                  pready
);

  // Payload counter holds up to MAX_PAYLOAD
  localparam int CNT_W = (MAX_PAYLOAD < 2) ? 1 : $clog2(MAX_PAYLOAD + 1);
  localparam logic [crcrd_pkg::FRAME_W:0] MAX_LEN = (crcrd_pkg::FRAME_W + 1)'(MAX_PAYLOAD);

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_PAYLOAD,
    PH_CRC_FIRST,
    PH_CRC_SECOND,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [crcrd_pkg::BYTE_W-1:0]    payload_byte;
    logic                            is_status;
    logic [crcrd_pkg::STATUS_W-1:0]  status;
    logic [crcrd_pkg::OUT_LEN_W-1:0] payload_length;
  } result_t;

  // --------------------------------------------------------------------------
  // Configuration registers; word index is paddr[2]
  // --------------------------------------------------------------------------
  logic [crcrd_pkg::BYTE_W-1:0] expected_address;
  logic [crcrd_pkg::BYTE_W-1:0] expected_opcode;
  logic                         cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_address <= crcrd_pkg::ADDRESS_RESET;
      expected_opcode  <= crcrd_pkg::OPCODE_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == crcrd_pkg::REG_ADDRESS) begin
        expected_address <= pwdata[crcrd_pkg::BYTE_W-1:0];
      end else begin
        expected_opcode <= pwdata[crcrd_pkg::BYTE_W-1:0];
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == crcrd_pkg::REG_ADDRESS) begin
      prdata[crcrd_pkg::BYTE_W-1:0] = expected_address;
    end else begin
      prdata[crcrd_pkg::BYTE_W-1:0] = expected_opcode;
    end
  end

  // --------------------------------------------------------------------------
  // Frame state and result registers
  // --------------------------------------------------------------------------
  phase_t                          phase, phase_next;
  logic [1:0]                      hdr_idx, hdr_idx_next;
  logic [CNT_W-1:0]                byte_count, byte_count_next;
  logic [crcrd_pkg::FRAME_W-1:0]   frame_length, frame_length_next;
  logic                            header_match, header_match_next;
  logic [crcrd_pkg::BYTE_W-1:0]    first_crc_byte, first_crc_byte_next;

  result_t                         out_q, out_q_next;
  logic                            out_valid_next;
  result_t                         skid, skid_next;
  logic                            skid_valid, skid_valid_next;

  result_t                         res;
  logic                            res_valid;
  crcrd_pkg::crc_ctl_t             crc_ctl;
  logic [crcrd_pkg::CRC_W-1:0]     crc;

  logic                            in_fire;
  logic                            out_fire;
  logic [crcrd_pkg::FRAME_W-1:0]   len_full;
  logic [crcrd_pkg::FRAME_W:0]     count_inc;
  logic [crcrd_pkg::OUT_LEN_W-1:0] sat_len;
  logic [crcrd_pkg::OUT_LEN_W-1:0] sat_len_full;

  assign in_stall = skid_valid;
  assign in_fire  = in_valid & ~in_stall;
  assign out_fire = out_valid & ~out_stall;

  // Length as it stands once the fourth header byte lands
  assign len_full  = {frame_length[crcrd_pkg::FRAME_W-1:crcrd_pkg::BYTE_W], line_byte};
  assign count_inc = (crcrd_pkg::FRAME_W + 1)'(byte_count) + 1'b1;

  // Saturate the reported length at the width of the payload_length field
  assign sat_len = (frame_length > crcrd_pkg::FRAME_W'(crcrd_pkg::LEN_SAT))
                 ? crcrd_pkg::LEN_SAT : frame_length[crcrd_pkg::OUT_LEN_W-1:0];
  assign sat_len_full = (len_full > crcrd_pkg::FRAME_W'(crcrd_pkg::LEN_SAT))
                      ? crcrd_pkg::LEN_SAT : len_full[crcrd_pkg::OUT_LEN_W-1:0];

  crcrd_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .ctl  (crc_ctl),
    .data (line_byte),
    .crc  (crc)
  );

  always_comb begin
    phase_next          = phase;
    hdr_idx_next        = hdr_idx;
    byte_count_next     = byte_count;
    frame_length_next   = frame_length;
    header_match_next   = header_match;
    first_crc_byte_next = first_crc_byte;
    res                 = '0;
    res_valid           = 1'b0;
    crc_ctl             = '0;

    if (in_fire) begin
      case (command)
        crcrd_pkg::CMD_START: begin
          // Rearm: drop any open frame without a status item
          phase_next          = PH_HEADER;
          hdr_idx_next        = '0;
          byte_count_next     = '0;
          frame_length_next   = '0;
          header_match_next   = 1'b1;
          first_crc_byte_next = '0;
          crc_ctl.rearm       = 1'b1;
        end
        crcrd_pkg::CMD_TIMEOUT: begin
          if (phase != PH_DONE) begin
            res_valid          = 1'b1;
            res.is_status      = 1'b1;
            res.status         = crcrd_pkg::ST_SHORT;
            res.payload_length = (phase == PH_HEADER) ? '0 : sat_len;
            phase_next         = PH_DONE;
          end
        end
        crcrd_pkg::CMD_BYTE: begin
          case (phase)
            PH_HEADER: begin
              crc_ctl.absorb = 1'b1;
              hdr_idx_next   = hdr_idx + 2'd1;
              case (hdr_idx)
                2'd0: begin
                  if (line_byte != expected_address) header_match_next = 1'b0;
                end
                2'd1: begin
                  if (line_byte != expected_opcode) header_match_next = 1'b0;
                end
                2'd2: begin
                  frame_length_next = {line_byte, 8'h00};
                end
                default: begin
                  frame_length_next = len_full;
                  byte_count_next   = '0;
                  if ({1'b0, len_full} > MAX_LEN) begin
                    // Too long: close the frame on the last header byte
                    res_valid          = 1'b1;
                    res.is_status      = 1'b1;
                    res.status         = crcrd_pkg::ST_TOO_LONG;
                    res.payload_length = sat_len_full;
                    phase_next         = PH_DONE;
                  end else if (len_full != '0) begin
                    phase_next = PH_PAYLOAD;
                  end else begin
                    phase_next = PH_CRC_FIRST;
                  end
                end
              endcase
            end
            PH_PAYLOAD: begin
              crc_ctl.absorb   = 1'b1;
              byte_count_next  = count_inc[CNT_W-1:0];
              if (count_inc >= {1'b0, frame_length}) phase_next = PH_CRC_FIRST;
              res_valid        = 1'b1;
              res.payload_byte = line_byte;
            end
            PH_CRC_FIRST: begin
              first_crc_byte_next = line_byte;
              phase_next          = PH_CRC_SECOND;
            end
            PH_CRC_SECOND: begin
              // CRC is sent low byte first; a CRC error outranks a mismatch
              res_valid          = 1'b1;
              res.is_status      = 1'b1;
              res.payload_length = sat_len;
              if (first_crc_byte != crc[7:0] || line_byte != crc[15:8]) begin
                res.status = crcrd_pkg::ST_BAD_CRC;
              end else if (!header_match) begin
                res.status = crcrd_pkg::ST_MISMATCH;
              end else begin
                res.status = crcrd_pkg::ST_OK;
              end
              phase_next = PH_DONE;
            end
            default: ;  // done: ignore line bytes until rearmed
          endcase
        end
        default: ;  // unused command
      endcase
    end

    // Output register with one skid entry behind it
    out_q_next      = out_q;
    out_valid_next  = out_valid;
    skid_next       = skid;
    skid_valid_next = skid_valid;
    if (skid_valid) begin
      if (out_fire) begin
        out_q_next      = skid;
        out_valid_next  = 1'b1;
        skid_valid_next = 1'b0;
      end
    end else if (!out_valid || out_fire) begin
      out_valid_next = res_valid;
      if (res_valid) out_q_next = res;
    end else if (res_valid) begin
      skid_next       = res;
      skid_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HEADER;
      hdr_idx        <= '0;
      byte_count     <= '0;
      frame_length   <= '0;
      header_match   <= 1'b1;
      first_crc_byte <= '0;
      out_valid      <= 1'b0;
      skid_valid     <= 1'b0;
    end else begin
      phase          <= phase_next;
      hdr_idx        <= hdr_idx_next;
      byte_count     <= byte_count_next;
      frame_length   <= frame_length_next;
      header_match   <= header_match_next;
      first_crc_byte <= first_crc_byte_next;
      out_valid      <= out_valid_next;
      skid_valid     <= skid_valid_next;
    end
    out_q <= out_q_next;
    skid  <= skid_next;
  end

  assign payload_byte   = out_q.payload_byte;
  assign is_status      = out_q.is_status;
  assign status         = out_q.status;
  assign payload_length = out_q.payload_length;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_skid_behind_out : assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_done_sticky : assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) && !(in_fire && command == crcrd_pkg::CMD_START)
    |=> phase == PH_DONE)
    else $error("frame reopened without a start command");

  a_rearm : assert property (@(posedge clk) disable iff (rst)
    in_fire && command == crcrd_pkg::CMD_START
    |=> phase == PH_HEADER && crc == crcrd_pkg::CRC_INIT && header_match)
    else $error("start command did not rearm the deframer");

  a_data_clean : assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_status |-> status == crcrd_pkg::ST_OK && payload_length == '0)
    else $error("data item carries status fields");

  a_payload_len : assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> frame_length != '0 && {1'b0, frame_length} <= MAX_LEN
    && (crcrd_pkg::FRAME_W + 1)'(byte_count) < {1'b0, frame_length})
    else $error("payload phase with out-of-range length or count");

endmodule
`default_nettype wire

### hdl/crcrd_crc_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crcrd_crc_unit
// Running CRC-16/MODBUS register: absorb one byte per cycle, rearm to init.
// ----------------------------------------------------------------------------
module crcrd_crc_unit (
  input  wire                              clk,
  input  wire                              rst,
  input  wire  crcrd_pkg::crc_ctl_t        ctl,
  input  wire  [crcrd_pkg::BYTE_W-1:0]     data,
  output logic [crcrd_pkg::CRC_W-1:0]      crc
);

  logic [crcrd_pkg::CRC_W-1:0] crc_next;

  always_comb begin
    crc_next = crc;
    if (ctl.rearm) begin
      crc_next = crcrd_pkg::CRC_INIT;
    end else if (ctl.absorb) begin
      crc_next = crcrd_pkg::crc16_byte(crc, data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= crcrd_pkg::CRC_INIT;
    end else begin
      crc <= crc_next;
    end
  end

endmodule
`default_nettype wire
